FILE: hw/rtl/ufrb_pkg.sv
package ufrb_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_SLOT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CONTROL = 3'd0,
    REG_STATUS  = 3'd1,
    REG_DATA    = 3'd2,
    REG_RX_LVL  = 3'd3,
    REG_TX_LVL  = 3'd4,
    REG_CTS     = 3'd5,
    REG_BAUD    = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    FAULT_OK        = 3'd0,
    FAULT_READ_ONLY = 3'd1,
    FAULT_THRESHOLD = 3'd2,
    FAULT_ZERO_MOD  = 3'd3,
    FAULT_TX_FULL   = 3'd4,
    FAULT_RX_EMPTY  = 3'd5,
    FAULT_RX_DROP   = 3'd6,
    FAULT_BAD_INDEX = 3'd7
  } fault_e;

  typedef enum logic [2:0] {
    OP_READ_REG,
    OP_POP_RX,
    OP_WRITE_REG,
    OP_PUSH_TX,
    OP_IGNORE,
    OP_LINE_BYTE,
    OP_SEND_TX
  } op_e;

  localparam int unsigned BIT_TXE    = 0;
  localparam int unsigned BIT_RXE    = 1;
  localparam int unsigned BIT_MRXR   = 13;
  localparam int unsigned BIT_MTXR   = 14;
  localparam int unsigned BAUD_MOD_W = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  line_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  sent_byte;
    logic        sent_valid;
    logic        irq_level;
    logic [2:0]  fault_code;
  } out_t;

  typedef struct packed {
    op_e         op;
    reg_e        idx;
    logic [31:0] data;
    logic [7:0]  line_byte;
    fault_e      fault;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: hw/rtl/ufrb_front.sv
module ufrb_front
  import ufrb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  in_t  req_i,
  output cmd_t cmd_o
);

  kind_e kind;
  reg_e  idx;

  assign kind = kind_e'(req_i.kind);
  assign idx  = reg_e'(req_i.reg_index);

  always_comb begin
    cmd_o.idx       = idx;
    cmd_o.data      = req_i.write_data;
    cmd_o.line_byte = req_i.line_byte;
    cmd_o.op        = OP_IGNORE;
    cmd_o.fault     = FAULT_OK;
    case (kind)
      KIND_READ: begin
        cmd_o.op = (idx == REG_DATA) ? OP_POP_RX : OP_READ_REG;
        if (idx == REG_UNUSED) begin
          cmd_o.fault = FAULT_BAD_INDEX;
        end
      end
      KIND_WRITE: begin
        case (idx)
          REG_DATA: cmd_o.op = OP_PUSH_TX;
          REG_UNUSED: begin
            cmd_o.op    = OP_IGNORE;
            cmd_o.fault = FAULT_BAD_INDEX;
          end
          default: begin
            cmd_o.op = OP_WRITE_REG;
            if (idx == REG_STATUS) begin
              cmd_o.fault = FAULT_READ_ONLY;
            end else if ((idx == REG_RX_LVL || idx == REG_TX_LVL) &&
                         req_i.write_data >= 32'(FIFO_DEPTH)) begin
              cmd_o.fault = FAULT_THRESHOLD;
            end else if (idx == REG_BAUD &&
                         req_i.write_data[BAUD_MOD_W-1:0] == '0) begin
              cmd_o.fault = FAULT_ZERO_MOD;
            end
          end
        endcase
      end
      KIND_LINE: cmd_o.op = OP_LINE_BYTE;
      KIND_SLOT: cmd_o.op = OP_SEND_TX;
      default:   cmd_o.op = OP_IGNORE;
    endcase
  end

endmodule

FILE: hw/rtl/ufrb_queue.sv
module ufrb_queue
  import ufrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cmd_t        cmd_i,
  input  logic        pop_i,
  output cmd_t        cmd_o,
  output queue_stat_t stat_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign cmd_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/ufrb_back.sv
module ufrb_back
  import ufrb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic done_o,
  output out_t res_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

  logic [31:0]   control_q, control_d;
  logic [31:0]   rx_thr_q, rx_thr_d;
  logic [31:0]   tx_thr_q, tx_thr_d;
  logic [31:0]   cts_q, cts_d;
  logic [31:0]   baud_q, baud_d;
  logic [CW-1:0] tx_cnt_q, tx_cnt_d;
  logic [CW-1:0] rx_cnt_q, rx_cnt_d;
  logic [AW-1:0] tx_head_q, tx_head_d;
  logic [AW-1:0] tx_tail_q, tx_tail_d;
  logic [AW-1:0] rx_head_q, rx_head_d;
  logic [AW-1:0] rx_tail_q, rx_tail_d;
  logic          irq_q, irq_d;

  logic [7:0] tx_mem [FIFO_DEPTH];
  logic [7:0] rx_mem [FIFO_DEPTH];
  logic [7:0] tx_rd_q;
  logic [7:0] rx_rd_q;

  logic tx_push, rx_push;
  logic recompute;
  logic [31:0] tx_space;

  logic vld_q;
  out_t res_q, res_d;
  logic rx_sel_q, rx_sel_d;
  logic tx_sel_q, tx_sel_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
    ptr_inc = (ptr == LAST) ? '0 : ptr + AW'(1);
  endfunction

  always_comb begin
    control_d = control_q;
    rx_thr_d  = rx_thr_q;
    tx_thr_d  = tx_thr_q;
    cts_d     = cts_q;
    baud_d    = baud_q;
    tx_cnt_d  = tx_cnt_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_push   = 1'b0;
    rx_push   = 1'b0;
    recompute = 1'b0;
    rx_sel_d  = 1'b0;
    tx_sel_d  = 1'b0;
    res_d     = '0;
    res_d.fault_code = cmd_i.fault;

    if (cmd_valid_i) begin
      case (cmd_i.op)
        OP_READ_REG: begin
          case (cmd_i.idx)
            REG_CONTROL: res_d.read_data = control_q;
            REG_RX_LVL:  res_d.read_data = 32'(rx_cnt_q);
            REG_TX_LVL:  res_d.read_data = 32'(FIFO_DEPTH) - 32'(tx_cnt_q);
            REG_CTS:     res_d.read_data = cts_q;
            REG_BAUD:    res_d.read_data = baud_q;
            default:     res_d.read_data = '0;
          endcase
        end
        OP_POP_RX: begin
          if (rx_cnt_q != '0) begin
            rx_sel_d  = 1'b1;
            rx_head_d = ptr_inc(rx_head_q);
            rx_cnt_d  = rx_cnt_q - CW'(1);
          end else begin
            res_d.fault_code = FAULT_RX_EMPTY;
          end
        end
        OP_WRITE_REG: begin
          recompute = 1'b1;
          case (cmd_i.idx)
            REG_CONTROL: control_d = cmd_i.data;
            REG_RX_LVL:  rx_thr_d  = cmd_i.data;
            REG_TX_LVL:  tx_thr_d  = cmd_i.data;
            REG_CTS:     cts_d     = cmd_i.data;
            REG_BAUD:    baud_d    = cmd_i.data;
            default:     ;
          endcase
        end
        OP_PUSH_TX: begin
          recompute = 1'b1;
          if (tx_cnt_q < FULL) begin
            tx_push   = 1'b1;
            tx_tail_d = ptr_inc(tx_tail_q);
            tx_cnt_d  = tx_cnt_q + CW'(1);
          end else begin
            res_d.fault_code = FAULT_TX_FULL;
          end
        end
        OP_LINE_BYTE: begin
          if (control_q[BIT_RXE]) begin
            recompute = 1'b1;
            if (rx_cnt_q < FULL) begin
              rx_push   = 1'b1;
              rx_tail_d = ptr_inc(rx_tail_q);
              rx_cnt_d  = rx_cnt_q + CW'(1);
            end else begin
              res_d.fault_code = FAULT_RX_DROP;
            end
          end else begin
            res_d.fault_code = FAULT_RX_DROP;
          end
        end
        OP_SEND_TX: begin
          if (control_q[BIT_TXE] && tx_cnt_q != '0) begin
            recompute        = 1'b1;
            tx_sel_d         = 1'b1;
            res_d.sent_valid = 1'b1;
            tx_head_d        = ptr_inc(tx_head_q);
            tx_cnt_d         = tx_cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // interrupt level from the post-update state
  assign tx_space = 32'(FIFO_DEPTH) - 32'(tx_cnt_d);

  always_comb begin
    irq_d = irq_q;
    if (recompute) begin
      irq_d = (control_d[BIT_MTXR] && tx_space >= tx_thr_d) ||
              (control_d[BIT_MRXR] && 32'(rx_cnt_d) >= rx_thr_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= '0;
      rx_thr_q  <= '0;
      tx_thr_q  <= '0;
      cts_q     <= '0;
      baud_q    <= '0;
      tx_cnt_q  <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      irq_q     <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      control_q <= control_d;
      rx_thr_q  <= rx_thr_d;
      tx_thr_q  <= tx_thr_d;
      cts_q     <= cts_d;
      baud_q    <= baud_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      irq_q     <= irq_d;
      vld_q     <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    rx_sel_q <= rx_sel_d;
    tx_sel_q <= tx_sel_d;
  end

  // byte stores, read data registered at the head
  always_ff @(posedge clk_i) begin
    if (tx_push) begin
      tx_mem[tx_tail_q] <= cmd_i.data[7:0];
    end
    tx_rd_q <= tx_mem[tx_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (rx_push) begin
      rx_mem[rx_tail_q] <= cmd_i.line_byte;
    end
    rx_rd_q <= rx_mem[rx_head_q];
  end

  always_comb begin
    res_o           = res_q;
    res_o.irq_level = irq_q;
    if (rx_sel_q) begin
      res_o.read_data = {24'b0, rx_rd_q};
    end
    if (tx_sel_q) begin
      res_o.sent_byte = tx_rd_q;
    end
  end

  assign done_o = vld_q;

endmodule

FILE: hw/rtl/uart_fifo_register_block.sv
// channel   | direction | handshake              | payload
// request   | in        | start high, busy low   | req_i (in_t)
// result    | out       | done_o strobe, 1 cycle | res_o (out_t)
//
// one request per cycle sustained; the result strobe is raised once the request
// has passed through the queue entry register and the back end's result register
// (classify into the queue, then execute with the byte store read alongside)
// the back end drains the queued request every cycle, so the two-entry queue
// never fills and busy stays low
// reset clears settings, counts, pointers and flags, not the result or queue
// entries; the byte stores are not cleared and need no clearing pass
// results cannot be held off and are shown for exactly one cycle
module uart_fifo_register_block
  import ufrb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  req_i,
  output logic done_o,
  output out_t res_o
);

  cmd_t        front_cmd;
  cmd_t        queue_cmd;
  queue_stat_t queue_stat;
  logic        accept;

  assign busy   = queue_stat.full;
  assign accept = start && !queue_stat.full;

  ufrb_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .req_i(req_i),
    .cmd_o(front_cmd)
  );

  ufrb_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(accept),
    .cmd_i (front_cmd),
    .pop_i (!queue_stat.empty),
    .cmd_o (queue_cmd),
    .stat_o(queue_stat)
  );

  ufrb_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!queue_stat.empty),
    .cmd_i      (queue_cmd),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule
